// File: design/periodic_tick_timer_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Periodic tick timer table - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TICK_TIMER_TABLE_UNIT_MACROS_SVH
`define PERIODIC_TICK_TIMER_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define PTT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ptt_pkg.sv
// ----------------------------------------------------------------------------
// Periodic tick timer table - package
// Sizes, codes, memory entry layout and handle helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  localparam int SLOTS       = 32;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int OP_W        = 2;
  localparam int KIND_W      = 2;
  localparam int PERIOD_W    = 16;
  localparam int SEQ_W       = 16;
  localparam int TAG_W       = 32;
  localparam int HANDLE_W    = 21;
  localparam int SLOT_SHIFT  = 16;
  localparam int HSLOT_W     = HANDLE_W - SLOT_SHIFT;
  localparam int MAX_RESULTS = 32;
  localparam int FCNT_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD,
    OP_STOP,
    OP_CLEAR,
    OP_TICK
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED,
    KIND_BAD_PERIOD,
    KIND_FULL,
    KIND_FIRED
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CHECK,
    ST_SWEEP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] count;
    logic [SEQ_W-1:0]    seq;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

  typedef struct packed {
    logic              set;
    logic [SLOT_W-1:0] set_idx;
    logic              clr;
    logic [SLOT_W-1:0] clr_idx;
  } live_upd_t;

  typedef struct packed {
    logic                vld;
    kind_t               kind;
    logic [HANDLE_W-1:0] handle;
    logic [TAG_W-1:0]    tag;
    logic                last;
  } result_t;

  // slot in the upper bits, sequence in the low bits, cut to handle width
  function automatic logic [HANDLE_W-1:0] make_handle(input logic [SLOT_W-1:0] slot,
                                                      input logic [SEQ_W-1:0]  seq);
    logic [SLOT_W+SEQ_W-1:0] wide;
    wide = {slot, seq};
    return HANDLE_W'(wide);
  endfunction

endpackage

`default_nettype wire

// File: design/ptt_slot_mem.sv
// ----------------------------------------------------------------------------
// Periodic tick timer table - slot memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_slot_mem (
  input  wire logic                        clk,
  input  wire ptt_pkg::mem_wr_t            wr,
  input  wire logic [ptt_pkg::SLOT_W-1:0]  rd_addr,
  output      ptt_pkg::entry_t             rd_data
);
  import ptt_pkg::*;

  entry_t mem [SLOTS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: design/ptt_live.sv
// ----------------------------------------------------------------------------
// Periodic tick timer table - live bits
// Per-slot live flags and lowest-free-slot search.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_live (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ptt_pkg::live_upd_t          upd,
  output      logic [ptt_pkg::SLOTS-1:0]   live,
  output      logic                        free_vld,
  output      logic [ptt_pkg::SLOT_W-1:0]  free_idx
);
  import ptt_pkg::*;

  logic [SLOTS-1:0] live_r;
  logic [SLOTS-1:0] live_nxt;

  always_comb begin
    live_nxt = live_r;
    if (upd.clr) begin
      live_nxt[upd.clr_idx] = 1'b0;
    end
    if (upd.set) begin
      live_nxt[upd.set_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else begin
      live_r <= live_nxt;
    end
  end

  // lowest free slot wins
  always_comb begin
    free_vld = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_vld = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign live = live_r;

endmodule

`default_nettype wire

// File: design/ptt_out_reg.sv
// ----------------------------------------------------------------------------
// Periodic tick timer table - output register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_out_reg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ptt_pkg::result_t              push,
  output      logic                          free,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [ptt_pkg::KIND_W-1:0]    out_kind,
  output      logic [ptt_pkg::HANDLE_W-1:0]  out_timer_handle,
  output      logic [ptt_pkg::TAG_W-1:0]     out_tag_out,
  output      logic                          out_last
);
  import ptt_pkg::*;

  logic                out_vld_r;
  logic                out_vld_nxt;
  kind_t               kind_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [TAG_W-1:0]    tag_r;
  logic                last_r;

  assign free = !out_vld_r || out_ready;

  always_comb begin
    out_vld_nxt = out_vld_r && !out_ready;
    if (push.vld) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      kind_r   <= push.kind;
      handle_r <= push.handle;
      tag_r    <= push.tag;
      last_r   <= push.last;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = kind_r;
  assign out_timer_handle = handle_r;
  assign out_tag_out      = tag_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

// File: design/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// Periodic tick timer table - controller
// Request sequencing, handle check and the tick sweep over the slot memory.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_tick_timer_table_unit_macros.svh"

module ptt_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [ptt_pkg::OP_W-1:0]      in_op,
  input  wire logic [ptt_pkg::PERIOD_W-1:0]  in_period,
  input  wire logic [ptt_pkg::TAG_W-1:0]     in_user_tag,
  input  wire logic [ptt_pkg::HANDLE_W-1:0]  in_handle,
  input  wire logic [ptt_pkg::SLOTS-1:0]     live,
  input  wire logic                          free_vld,
  input  wire logic [ptt_pkg::SLOT_W-1:0]    free_idx,
  output      ptt_pkg::live_upd_t            live_upd,
  output      ptt_pkg::mem_wr_t              mem_wr,
  output      logic [ptt_pkg::SLOT_W-1:0]    rd_addr,
  input  wire ptt_pkg::entry_t               rd_data,
  output      ptt_pkg::result_t              push,
  input  wire logic                          out_free
);
  import ptt_pkg::*;

  state_t              state_r, state_nxt;
  op_t                 op_r;
  logic [PERIOD_W-1:0] period_r;
  logic [TAG_W-1:0]    tag_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic [CNT_W-1:0]    iss_idx_r, iss_idx_nxt;
  logic                ex_vld_r, ex_vld_nxt;
  logic [SLOT_W-1:0]   ex_idx_r, ex_idx_nxt;
  result_t             hold_r, hold_nxt;
  logic [FCNT_W-1:0]   fire_cnt_r, fire_cnt_nxt;

  logic                accept;
  logic [HSLOT_W-1:0]  hdl_slot;
  logic [SLOT_W-1:0]   hdl_idx;
  logic [SEQ_W-1:0]    hdl_seq;
  logic                hdl_match;
  logic [PERIOD_W:0]   cnt_inc;
  logic                ex_live;
  logic                ex_hit;
  logic                ex_report;
  logic                stall;
  logic                sweep_done;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // handle decode for stop / clear
  assign hdl_slot  = handle_r[HANDLE_W-1:SLOT_SHIFT];
  assign hdl_idx   = SLOT_W'(hdl_slot);
  assign hdl_seq   = handle_r[SEQ_W-1:0];
  assign hdl_match = (32'(hdl_slot) < 32'(SLOTS)) && live[hdl_idx] && (rd_data.seq == hdl_seq);

  // sweep execute stage
  assign cnt_inc    = {1'b0, rd_data.count} + (PERIOD_W+1)'(1);
  assign ex_live    = ex_vld_r && live[ex_idx_r];
  assign ex_hit     = cnt_inc >= {1'b0, rd_data.period};
  assign ex_report  = ex_live && ex_hit && (fire_cnt_r < FCNT_W'(MAX_RESULTS));
  assign stall      = (state_r == ST_SWEEP) && ex_report && hold_r.vld && !out_free;
  assign sweep_done = !ex_vld_r && (iss_idx_r == CNT_W'(SLOTS));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (op_r)
          OP_ADD: begin
            if (out_free) begin
              state_nxt = ST_IDLE;
            end
          end
          OP_STOP, OP_CLEAR: state_nxt = ST_CHECK;
          OP_TICK:           state_nxt = ST_SWEEP;
        endcase
      end
      ST_CHECK: state_nxt = ST_IDLE;
      ST_SWEEP: begin
        if (sweep_done) begin
          state_nxt = hold_r.vld ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    live_upd     = '0;
    mem_wr       = '0;
    push         = '0;
    rd_addr      = hdl_idx;
    seq_nxt      = seq_r;
    iss_idx_nxt  = iss_idx_r;
    ex_vld_nxt   = ex_vld_r;
    ex_idx_nxt   = ex_idx_r;
    hold_nxt     = hold_r;
    fire_cnt_nxt = fire_cnt_r;

    unique case (state_r)
      ST_IDLE: begin
      end
      ST_DISPATCH: begin
        unique case (op_r)
          OP_ADD: begin
            if (out_free) begin
              push.vld  = 1'b1;
              push.last = 1'b1;
              if (period_r == '0) begin
                push.kind = KIND_BAD_PERIOD;
              end else if (!free_vld) begin
                push.kind = KIND_FULL;
              end else begin
                push.kind        = KIND_ADDED;
                push.handle      = make_handle(free_idx, seq_r);
                mem_wr.we        = 1'b1;
                mem_wr.addr      = free_idx;
                mem_wr.data      = '{period: period_r, count: '0, seq: seq_r, tag: tag_r};
                live_upd.set     = 1'b1;
                live_upd.set_idx = free_idx;
                seq_nxt          = seq_r + SEQ_W'(1);
              end
            end
          end
          OP_STOP, OP_CLEAR: begin
            // read address is the handle's slot; checked next cycle
          end
          OP_TICK: begin
            iss_idx_nxt  = '0;
            ex_vld_nxt   = 1'b0;
            fire_cnt_nxt = '0;
            hold_nxt     = '0;
          end
        endcase
      end
      ST_CHECK: begin
        if (hdl_match) begin
          if (op_r == OP_STOP) begin
            live_upd.clr     = 1'b1;
            live_upd.clr_idx = hdl_idx;
          end else begin
            mem_wr.we         = 1'b1;
            mem_wr.addr       = hdl_idx;
            mem_wr.data       = rd_data;
            mem_wr.data.count = '0;
          end
        end
      end
      ST_SWEEP: begin
        if (stall) begin
          // re-read the same slot; nothing was written
          rd_addr = ex_idx_r;
        end else begin
          if (ex_live) begin
            mem_wr.we         = 1'b1;
            mem_wr.addr       = ex_idx_r;
            mem_wr.data       = rd_data;
            mem_wr.data.count = ex_hit ? '0 : cnt_inc[PERIOD_W-1:0];
          end
          if (ex_report) begin
            // previous fire is not the last one
            if (hold_r.vld) begin
              push      = hold_r;
              push.last = 1'b0;
            end
            hold_nxt.vld    = 1'b1;
            hold_nxt.kind   = KIND_FIRED;
            hold_nxt.handle = make_handle(ex_idx_r, rd_data.seq);
            hold_nxt.tag    = rd_data.tag;
            hold_nxt.last   = 1'b0;
            fire_cnt_nxt    = fire_cnt_r + FCNT_W'(1);
          end
          if (iss_idx_r < CNT_W'(SLOTS)) begin
            rd_addr     = iss_idx_r[SLOT_W-1:0];
            ex_vld_nxt  = 1'b1;
            ex_idx_nxt  = iss_idx_r[SLOT_W-1:0];
            iss_idx_nxt = iss_idx_r + CNT_W'(1);
          end else begin
            ex_vld_nxt = 1'b0;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push         = hold_r;
          push.last    = 1'b1;
          hold_nxt.vld = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      seq_r      <= '0;
      iss_idx_r  <= '0;
      ex_vld_r   <= 1'b0;
      hold_r     <= '0;
      fire_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      seq_r      <= seq_nxt;
      iss_idx_r  <= iss_idx_nxt;
      ex_vld_r   <= ex_vld_nxt;
      hold_r     <= hold_nxt;
      fire_cnt_r <= fire_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ex_idx_r <= ex_idx_nxt;
    if (accept) begin
      op_r     <= op_t'(in_op);
      period_r <= in_period;
      tag_r    <= in_user_tag;
      handle_r <= in_handle;
    end
  end

  `PTT_ASSERT_IMPLY(a_push_has_room, push.vld, out_free, "result pushed into a full output register")
  `PTT_ASSERT_IMPLY(a_hold_only_in_tick, hold_r.vld, (state_r == ST_SWEEP) || (state_r == ST_FLUSH), "pending fire outside a tick")
  `PTT_ASSERT_NEXT(a_stall_keeps_slot, stall, ex_vld_r && (ex_idx_r == $past(ex_idx_r)), "sweep moved on while stalled")
  `PTT_ASSERT_IMPLY(a_no_write_when_idle, mem_wr.we, state_r != ST_IDLE, "slot memory written while idle")

endmodule

`default_nettype wire

// File: design/periodic_tick_timer_table_unit.sv
// ----------------------------------------------------------------------------
// Periodic tick timer table - top level
// Table of periodic tick timers with add, stop, clear-count and tick requests.
// ----------------------------------------------------------------------------
// One request is worked at a time. An add goes from idle to a dispatch
// state that pushes its result into the output register once that register
// is free of the consumer; stop and clear go from dispatch to a check state
// and give no result.
// A tick sweeps every slot through the single read port of the slot memory,
// one slot per cycle while the consumer does not stall the fire results, and
// then passes through a flush state when any slot fired. Fires come out in
// ascending slot order; the last fire of a tick is held back in a register
// so it can carry the last flag. Live flags sit in flip-flops cleared at
// reset, so no memory clearing pass is needed; period, count, sequence and
// tag live in the slot memory, which the sweep reads for every slot, though
// only live slots are written back or fired.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_tick_timer_table_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request channel
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [ptt_pkg::OP_W-1:0]      in_op,
  input  wire logic [ptt_pkg::PERIOD_W-1:0]  in_period,
  input  wire logic [ptt_pkg::TAG_W-1:0]     in_user_tag,
  input  wire logic [ptt_pkg::HANDLE_W-1:0]  in_handle,
  // result channel
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [ptt_pkg::KIND_W-1:0]    out_kind,
  output      logic [ptt_pkg::HANDLE_W-1:0]  out_timer_handle,
  output      logic [ptt_pkg::TAG_W-1:0]     out_tag_out,
  output      logic                          out_last
);
  import ptt_pkg::*;

  logic [SLOTS-1:0]  live;
  logic              free_vld;
  logic [SLOT_W-1:0] free_idx;
  live_upd_t         live_upd;
  mem_wr_t           mem_wr;
  logic [SLOT_W-1:0] rd_addr;
  entry_t            rd_data;
  result_t           push;
  logic              out_free;

  // sequencer: request decode, handle match, tick sweep
  ptt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_period   (in_period),
    .in_user_tag (in_user_tag),
    .in_handle   (in_handle),
    .live        (live),
    .free_vld    (free_vld),
    .free_idx    (free_idx),
    .live_upd    (live_upd),
    .mem_wr      (mem_wr),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .push        (push),
    .out_free    (out_free)
  );

  // per-slot live flags, lowest free slot for add
  ptt_live u_live (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (live_upd),
    .live     (live),
    .free_vld (free_vld),
    .free_idx (free_idx)
  );

  // period / count / sequence / tag per slot
  ptt_slot_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result register toward the consumer
  ptt_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .free             (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_timer_handle (out_timer_handle),
    .out_tag_out      (out_tag_out),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire
